// ----- rtl/mlvc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the mecanum LQI velocity controller.
// Used by every module of the block; depends on nothing else.
package mlvc_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned IntegW = 32;
  localparam int unsigned DriveW = 44;
  localparam int unsigned SumW   = 18;
  localparam int unsigned KinW   = 14;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned CfgIdxW = 3;

  // Kinematic factors in Q.18: wheel radius over four, and that over (lx + ly).
  localparam logic signed [KinW-1:0] R4_Q18   = 14'sd5046;
  localparam logic signed [KinW-1:0] YAWK_Q18 = 14'sd3906;

  localparam logic [DataW-1:0] TICK_RESET = 16'd328;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_YAW_ERR = 3'd0,
    CFG_GAIN_YAW_INT = 3'd1,
    CFG_GAIN_X_ERR   = 3'd2,
    CFG_GAIN_X_INT   = 3'd3,
    CFG_GAIN_Y_ERR   = 3'd4,
    CFG_GAIN_Y_INT   = 3'd5,
    CFG_TICK_PERIOD  = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_INTEG,
    ST_IMUL,
    ST_DRIVE,
    ST_WHEEL,
    ST_KMUL,
    ST_KOUT
  } state_e;

  // One strobe per step of the per-word sequence.
  typedef struct packed {
    logic ld_err;
    logic ld_mul;
    logic ld_integ;
    logic ld_imul;
    logic ld_drive;
    logic ld_wheel;
    logic ld_kmul;
  } step_t;

  function automatic logic signed [DataW-1:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [IntegW-1:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (v < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[IntegW-1:0];
  endfunction

  function automatic logic signed [ProdW-1:0] kin_mul(input logic signed [SumW-1:0] s,
                                                       input logic signed [KinW-1:0] k);
    return 32'(s) * 32'(k);
  endfunction

  // Round half up from Q.28 to Q.10 and saturate.
  function automatic logic signed [DataW-1:0] kin_round(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] r;
    r = (p + 32'sd131072) >>> 18;
    return sat16(48'(r));
  endfunction

endpackage

// ----- rtl/mlvc_if.sv -----
// Valid/ready channel interfaces for the controller's input and result words.
// Standalone; payload fields are signed Q5.10.
interface mlvc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] goal_vx;
  logic signed [15:0] goal_vy;
  logic signed [15:0] goal_wz;
  logic signed [15:0] wheel_front_right;
  logic signed [15:0] wheel_front_left;
  logic signed [15:0] wheel_rear_left;
  logic signed [15:0] wheel_rear_right;

  modport source (output valid, goal_vx, goal_vy, goal_wz, wheel_front_right,
                  wheel_front_left, wheel_rear_left, wheel_rear_right, input ready);
  modport sink (input valid, goal_vx, goal_vy, goal_wz, wheel_front_right,
                wheel_front_left, wheel_rear_left, wheel_rear_right, output ready);
endinterface

interface mlvc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_wheel_one;
  logic signed [15:0] cmd_wheel_two;
  logic signed [15:0] cmd_wheel_three;
  logic signed [15:0] cmd_wheel_four;
  logic signed [15:0] twist_vx;
  logic signed [15:0] twist_vy;
  logic signed [15:0] twist_wz;
  logic signed [15:0] err_vx;
  logic signed [15:0] err_vy;
  logic signed [15:0] err_wz;

  modport source (output valid, cmd_wheel_one, cmd_wheel_two, cmd_wheel_three,
                  cmd_wheel_four, twist_vx, twist_vy, twist_wz, err_vx, err_vy, err_wz,
                  input ready);
  modport sink (input valid, cmd_wheel_one, cmd_wheel_two, cmd_wheel_three,
                cmd_wheel_four, twist_vx, twist_vy, twist_wz, err_vx, err_vy, err_wz,
                output ready);
endinterface

// ----- rtl/mlvc_axis_lane.sv -----
// One axis lane: error, integrator update and drive term in Q.18.
// Depends on mlvc_pkg.
module mlvc_axis_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mlvc_pkg::step_t                      step_i,
  input  logic signed [mlvc_pkg::DataW-1:0]    goal_i,
  input  logic signed [mlvc_pkg::DataW-1:0]    est_i,
  input  logic signed [mlvc_pkg::DataW-1:0]    gain_e_i,
  input  logic signed [mlvc_pkg::DataW-1:0]    gain_i_i,
  input  logic        [mlvc_pkg::DataW-1:0]    tick_period_i,
  output logic signed [mlvc_pkg::DataW-1:0]    err_o,
  output logic signed [mlvc_pkg::DriveW-1:0]   drive_o
);
  import mlvc_pkg::*;

  logic signed [DataW-1:0]  err_q;
  logic signed [32:0]       inc_q;
  logic signed [31:0]       pe_q;
  logic signed [47:0]       pi_q;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [DriveW-1:0] drive_q;

  logic signed [16:0] diff;
  logic signed [16:0] tp_s;
  logic signed [32:0] inc_r;
  logic signed [48:0] term;

  assign diff  = 17'(goal_i) - 17'(est_i);
  assign tp_s  = {1'b0, tick_period_i};
  assign inc_r = (inc_q + 33'sd512) >>> 10;
  assign term  = (49'(pi_q) + 49'sd32) >>> 6;

  // A zero setpoint clears the integrator, which also zeroes the integral term.
  always_comb begin
    if (goal_i == '0) begin
      integ_d = '0;
    end else begin
      integ_d = sat32(34'(integ_q) + 34'(inc_r));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (step_i.ld_integ) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.ld_err) begin
      err_q <= sat16(48'(diff));
    end
    if (step_i.ld_mul) begin
      inc_q <= 33'(err_q) * 33'(tp_s);
      pe_q  <= 32'(err_q) * 32'(gain_e_i);
    end
    if (step_i.ld_imul) begin
      pi_q <= 48'(gain_i_i) * 48'(integ_q);
    end
    if (step_i.ld_drive) begin
      drive_q <= 44'(pe_q) + 44'(term);
    end
  end

  assign err_o   = err_q;
  assign drive_o = drive_q;

endmodule

// ----- rtl/mlvc_estimator.sv -----
// Body-velocity estimate from measured wheel speeds via forward kinematics.
// Depends on mlvc_pkg.
module mlvc_estimator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mlvc_pkg::step_t                   step_i,
  input  logic signed [mlvc_pkg::DataW-1:0] m1_i,
  input  logic signed [mlvc_pkg::DataW-1:0] m2_i,
  input  logic signed [mlvc_pkg::DataW-1:0] m3_i,
  input  logic signed [mlvc_pkg::DataW-1:0] m4_i,
  output logic signed [mlvc_pkg::DataW-1:0] est_vx_o,
  output logic signed [mlvc_pkg::DataW-1:0] est_vy_o,
  output logic signed [mlvc_pkg::DataW-1:0] est_wz_o
);
  import mlvc_pkg::*;

  logic signed [SumW-1:0]  sx_q, sy_q, sw_q;
  logic signed [ProdW-1:0] px_q, py_q, pw_q;
  logic signed [DataW-1:0] est_vx_q, est_vy_q, est_wz_q;

  always_ff @(posedge clk_i) begin
    if (step_i.ld_err) begin
      sx_q <= 18'(m1_i) + 18'(m2_i) + 18'(m3_i) + 18'(m4_i);
      sy_q <= 18'(m1_i) - 18'(m2_i) + 18'(m3_i) - 18'(m4_i);
      sw_q <= 18'(m1_i) - 18'(m2_i) - 18'(m3_i) + 18'(m4_i);
    end
    if (step_i.ld_mul) begin
      px_q <= kin_mul(sx_q, R4_Q18);
      py_q <= kin_mul(sy_q, R4_Q18);
      pw_q <= kin_mul(sw_q, YAWK_Q18);
    end
  end

  // The new estimate lands after the lanes have taken the old one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_vx_q <= '0;
      est_vy_q <= '0;
      est_wz_q <= '0;
    end else if (step_i.ld_integ) begin
      est_vx_q <= kin_round(px_q);
      est_vy_q <= kin_round(py_q);
      est_wz_q <= kin_round(pw_q);
    end
  end

  assign est_vx_o = est_vx_q;
  assign est_vy_o = est_vy_q;
  assign est_wz_o = est_wz_q;

endmodule

// ----- rtl/mlvc_merge.sv -----
// Merging stage: wheel commands from the three lane drives, then their twist.
// Depends on mlvc_pkg.
module mlvc_merge (
  input  logic                               clk_i,
  input  mlvc_pkg::step_t                    step_i,
  input  logic signed [mlvc_pkg::DriveW-1:0] drive_x_i,
  input  logic signed [mlvc_pkg::DriveW-1:0] drive_y_i,
  input  logic signed [mlvc_pkg::DriveW-1:0] drive_w_i,
  output logic signed [mlvc_pkg::DataW-1:0]  w1_o,
  output logic signed [mlvc_pkg::DataW-1:0]  w2_o,
  output logic signed [mlvc_pkg::DataW-1:0]  w3_o,
  output logic signed [mlvc_pkg::DataW-1:0]  w4_o,
  output logic signed [mlvc_pkg::DataW-1:0]  twist_vx_o,
  output logic signed [mlvc_pkg::DataW-1:0]  twist_vy_o,
  output logic signed [mlvc_pkg::DataW-1:0]  twist_wz_o
);
  import mlvc_pkg::*;

  localparam int unsigned MixW = DriveW + 2;

  logic signed [MixW-1:0] px, py, pw;
  logic signed [MixW-1:0] s1, s2, s3, s4;
  logic signed [DataW-1:0] w1_q, w2_q, w3_q, w4_q;
  logic signed [ProdW-1:0] tx_q, ty_q, tw_q;

  function automatic logic signed [DataW-1:0] cmd_round(input logic signed [MixW-1:0] s);
    logic signed [MixW-1:0] r;
    r = (s + 46'sd128) >>> 8;
    return sat16(48'(r));
  endfunction

  assign px = MixW'(drive_x_i);
  assign py = MixW'(drive_y_i);
  assign pw = MixW'(drive_w_i);
  assign s1 = -pw - px - py;
  assign s2 =  pw - px + py;
  assign s3 =  pw - px - py;
  assign s4 = -pw - px + py;

  always_ff @(posedge clk_i) begin
    if (step_i.ld_wheel) begin
      w1_q <= cmd_round(s1);
      w2_q <= cmd_round(s2);
      w3_q <= cmd_round(s3);
      w4_q <= cmd_round(s4);
    end
    if (step_i.ld_kmul) begin
      tx_q <= kin_mul(18'(w1_q) + 18'(w2_q) + 18'(w3_q) + 18'(w4_q), R4_Q18);
      ty_q <= kin_mul(18'(w1_q) - 18'(w2_q) + 18'(w3_q) - 18'(w4_q), R4_Q18);
      tw_q <= kin_mul(18'(w1_q) - 18'(w2_q) - 18'(w3_q) + 18'(w4_q), YAWK_Q18);
    end
  end

  assign w1_o       = w1_q;
  assign w2_o       = w2_q;
  assign w3_o       = w3_q;
  assign w4_o       = w4_q;
  assign twist_vx_o = kin_round(tx_q);
  assign twist_vy_o = kin_round(ty_q);
  assign twist_wz_o = kin_round(tw_q);

endmodule

// ----- rtl/mecanum_lqi_velocity_control.sv -----
// Mecanum LQI velocity controller, top level.
// An accepted word passes ST_ERR to ST_KMUL; ST_KOUT then loads the output register.
// The nine-step sequencer that drives the lanes takes a new word only in ST_IDLE.
// A finished result waits in the output register; the sequencer stalls only if it is still full.
// Reset (async, active low) clears integrators, estimate, gains; tick period returns to 328.
module mecanum_lqi_velocity_control (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mlvc_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [mlvc_pkg::DataW-1:0]            cfg_data_i,
  mlvc_in_if.sink                               in_if,
  mlvc_out_if.source                            out_if
);
  import mlvc_pkg::*;

  // Configuration registers. Write only while the block is idle; it does not enforce this.
  logic signed [DataW-1:0] gain_yaw_err_q, gain_yaw_int_q;
  logic signed [DataW-1:0] gain_x_err_q, gain_x_int_q;
  logic signed [DataW-1:0] gain_y_err_q, gain_y_int_q;
  logic        [DataW-1:0] tick_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_yaw_err_q <= '0;
      gain_yaw_int_q <= '0;
      gain_x_err_q   <= '0;
      gain_x_int_q   <= '0;
      gain_y_err_q   <= '0;
      gain_y_int_q   <= '0;
      tick_period_q  <= TICK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_YAW_ERR: gain_yaw_err_q <= cfg_data_i;
        CFG_GAIN_YAW_INT: gain_yaw_int_q <= cfg_data_i;
        CFG_GAIN_X_ERR:   gain_x_err_q   <= cfg_data_i;
        CFG_GAIN_X_INT:   gain_x_int_q   <= cfg_data_i;
        CFG_GAIN_Y_ERR:   gain_y_err_q   <= cfg_data_i;
        CFG_GAIN_Y_INT:   gain_y_int_q   <= cfg_data_i;
        CFG_TICK_PERIOD:  tick_period_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input word is captured on acceptance and held for the whole sequence.
  logic signed [DataW-1:0] goal_vx_q, goal_vy_q, goal_wz_q;
  logic signed [DataW-1:0] m1_q, m2_q, m3_q, m4_q;

  state_e state_q, state_d;
  step_t  step;
  logic   in_accept;
  logic   out_load;
  logic   out_valid_q;

  assign in_accept = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      goal_vx_q <= in_if.goal_vx;
      goal_vy_q <= in_if.goal_vy;
      goal_wz_q <= in_if.goal_wz;
      m1_q      <= in_if.wheel_front_right;
      m2_q      <= in_if.wheel_front_left;
      m3_q      <= in_if.wheel_rear_left;
      m4_q      <= in_if.wheel_rear_right;
    end
  end

  // Sequencer: ST_ERR to ST_KMUL each fire one step strobe, seen by lanes, estimator and merge.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_ERR;
      ST_ERR:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_INTEG;
      ST_INTEG: state_d = ST_IMUL;
      ST_IMUL:  state_d = ST_DRIVE;
      ST_DRIVE: state_d = ST_WHEEL;
      ST_WHEEL: state_d = ST_KMUL;
      ST_KMUL:  state_d = ST_KOUT;
      ST_KOUT:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    step        = '0;
    in_if.ready = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE:  in_if.ready   = 1'b1;
      ST_ERR:   step.ld_err   = 1'b1;
      ST_MUL:   step.ld_mul   = 1'b1;
      ST_INTEG: step.ld_integ = 1'b1;
      ST_IMUL:  step.ld_imul  = 1'b1;
      ST_DRIVE: step.ld_drive = 1'b1;
      ST_WHEEL: step.ld_wheel = 1'b1;
      ST_KMUL:  step.ld_kmul  = 1'b1;
      ST_KOUT:  out_load      = !out_valid_q || out_if.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Three axis lanes run side by side; the estimate they read is last tick's.
  logic signed [DataW-1:0]  est_vx, est_vy, est_wz;
  logic signed [DataW-1:0]  err_x, err_y, err_w;
  logic signed [DriveW-1:0] drive_x, drive_y, drive_w;

  mlvc_axis_lane u_lane_x (
    .clk_i, .rst_ni, .step_i(step),
    .goal_i(goal_vx_q), .est_i(est_vx),
    .gain_e_i(gain_x_err_q), .gain_i_i(gain_x_int_q),
    .tick_period_i(tick_period_q),
    .err_o(err_x), .drive_o(drive_x)
  );

  mlvc_axis_lane u_lane_y (
    .clk_i, .rst_ni, .step_i(step),
    .goal_i(goal_vy_q), .est_i(est_vy),
    .gain_e_i(gain_y_err_q), .gain_i_i(gain_y_int_q),
    .tick_period_i(tick_period_q),
    .err_o(err_y), .drive_o(drive_y)
  );

  mlvc_axis_lane u_lane_w (
    .clk_i, .rst_ni, .step_i(step),
    .goal_i(goal_wz_q), .est_i(est_wz),
    .gain_e_i(gain_yaw_err_q), .gain_i_i(gain_yaw_int_q),
    .tick_period_i(tick_period_q),
    .err_o(err_w), .drive_o(drive_w)
  );

  mlvc_estimator u_est (
    .clk_i, .rst_ni, .step_i(step),
    .m1_i(m1_q), .m2_i(m2_q), .m3_i(m3_q), .m4_i(m4_q),
    .est_vx_o(est_vx), .est_vy_o(est_vy), .est_wz_o(est_wz)
  );

  logic signed [DataW-1:0] w1, w2, w3, w4, tvx, tvy, twz;

  mlvc_merge u_merge (
    .clk_i, .step_i(step),
    .drive_x_i(drive_x), .drive_y_i(drive_y), .drive_w_i(drive_w),
    .w1_o(w1), .w2_o(w2), .w3_o(w3), .w4_o(w4),
    .twist_vx_o(tvx), .twist_vy_o(tvy), .twist_wz_o(twz)
  );

  // Output register holds the result word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_if.cmd_wheel_one   <= w1;
      out_if.cmd_wheel_two   <= w2;
      out_if.cmd_wheel_three <= w3;
      out_if.cmd_wheel_four  <= w4;
      out_if.twist_vx        <= tvx;
      out_if.twist_vy        <= tvy;
      out_if.twist_wz        <= twz;
      out_if.err_vx          <= err_x;
      out_if.err_vy          <= err_y;
      out_if.err_wz          <= err_w;
    end
  end

  assign out_if.valid = out_valid_q;

endmodule

// ----- bench/mecanum_lqi_velocity_control_tb.sv -----
// Self-checking bench for the mecanum LQI velocity controller: directed plan, then random phases.
// Depends on mlvc_pkg, the channel interfaces in mlvc_if and the top level of the block.
module mecanum_lqi_velocity_control_tb;
  import mlvc_pkg::*;

  localparam int unsigned ClkPeriod     = 20;
  // The hold-off is the longest quiet stretch a correct run has, so the watchdog sits well above it.
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned WindupPhases  = 4;
  // Four windup phases of this length hold the forward setpoint near full scale long
  // enough for the forward integrator to reach its 32-bit clamp.
  localparam int unsigned WindupTicks   = 270;
  localparam int unsigned MixedTicks    = 20;
  localparam int unsigned MaxReports    = 10;

  // Index 7 has no register behind it; writes there must be ignored.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  // Kinematic factors in Q.18, kept separate from the RTL's own copy.
  localparam longint RadiusQuarter = 5046;
  localparam longint YawFactor     = 3906;

  typedef struct packed {
    logic signed [15:0] goal_vx, goal_vy, goal_wz;
    logic signed [15:0] wheel_fr, wheel_fl, wheel_rl, wheel_rr;
  } tick_in_t;

  typedef struct packed {
    logic signed [15:0] cmd_one, cmd_two, cmd_three, cmd_four;
    logic signed [15:0] twist_vx, twist_vy, twist_wz;
    logic signed [15:0] err_vx, err_vy, err_wz;
  } tick_out_t;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_KNOWN,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [DataW-1:0]   reg_val;
    tick_in_t           word;
    tick_out_t          known;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_data_i;

  mlvc_in_if  in_ch();
  mlvc_out_if out_ch();

  mecanum_lqi_velocity_control dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // Mirror of the register file and the controller state, updated in step with the block.
  logic signed [15:0] k_gain_yaw_err, k_gain_yaw_int;
  logic signed [15:0] k_gain_x_err, k_gain_x_int;
  logic signed [15:0] k_gain_y_err, k_gain_y_int;
  logic [15:0]        k_tick;
  logic signed [31:0] acc_vx, acc_vy, acc_wz;
  logic signed [15:0] body_vx, body_vy, body_wz;

  // Commands predicted for words already accepted, oldest first.
  tick_out_t pending_cmds[$];
  plan_row_t plan[$];

  bit          idle_on;
  bit          hold_req;
  int unsigned ticks_sent;
  int unsigned reg_writes;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned clamp_hits;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Round half up: add half an LSB of the target, then floor by an arithmetic shift.
  function automatic longint round_half_up(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  // Wheel sum (Q.10) times a Q.18 factor, back to Q.10.
  function automatic logic signed [15:0] kin_scale(longint s, longint k);
    return clamp16(round_half_up(s * k, 18));
  endfunction

  // One axis: error, integrator step, and the drive term in Q.18.
  function automatic longint axis_drive(input logic signed [15:0] goal, est,
                                        input logic signed [15:0] gain_e, gain_i,
                                        inout logic signed [31:0] acc,
                                        output logic signed [15:0] err);
    longint sum;
    longint term;
    err = clamp16(longint'(goal) - longint'(est));
    sum = longint'(acc) + round_half_up(longint'(err) * longint'(k_tick), 10);
    acc = clamp32(sum);
    if (sum != longint'(acc)) clamp_hits++;
    // A zero setpoint clears the integrator and drops its term on this very tick.
    if (goal == 16'sd0) begin
      acc  = '0;
      term = 0;
    end else begin
      term = round_half_up(longint'(gain_i) * longint'(acc), 6);
    end
    return longint'(gain_e) * longint'(err) + term;
  endfunction

  // Full control tick: returns the expected result word and advances the mirrored state.
  function automatic tick_out_t control_tick(tick_in_t w);
    tick_out_t r;
    logic signed [15:0] ex, ey, ew;
    longint px, py, pw;
    longint w1, w2, w3, w4;
    longint m1, m2, m3, m4;
    px = axis_drive(w.goal_vx, body_vx, k_gain_x_err, k_gain_x_int, acc_vx, ex);
    py = axis_drive(w.goal_vy, body_vy, k_gain_y_err, k_gain_y_int, acc_vy, ey);
    pw = axis_drive(w.goal_wz, body_wz, k_gain_yaw_err, k_gain_yaw_int, acc_wz, ew);
    r.cmd_one   = clamp16(round_half_up(-pw - px - py, 8));
    r.cmd_two   = clamp16(round_half_up(pw - px + py, 8));
    r.cmd_three = clamp16(round_half_up(pw - px - py, 8));
    r.cmd_four  = clamp16(round_half_up(-pw - px + py, 8));
    // The twist is taken from the saturated wheel commands.
    w1 = longint'(r.cmd_one);
    w2 = longint'(r.cmd_two);
    w3 = longint'(r.cmd_three);
    w4 = longint'(r.cmd_four);
    r.twist_vx = kin_scale(w1 + w2 + w3 + w4, RadiusQuarter);
    r.twist_vy = kin_scale(w1 - w2 + w3 - w4, RadiusQuarter);
    r.twist_wz = kin_scale(w1 - w2 - w3 + w4, YawFactor);
    r.err_vx = ex;
    r.err_vy = ey;
    r.err_wz = ew;
    // The measured wheels only shape the estimate used by the next tick.
    m1 = longint'(w.wheel_fr);
    m2 = longint'(w.wheel_fl);
    m3 = longint'(w.wheel_rl);
    m4 = longint'(w.wheel_rr);
    body_vx = kin_scale(m1 + m2 + m3 + m4, RadiusQuarter);
    body_vy = kin_scale(m1 - m2 + m3 - m4, RadiusQuarter);
    body_wz = kin_scale(m1 - m2 - m3 + m4, YawFactor);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tick_in_t tk(logic signed [15:0] gx, gy, gw, fr, fl, rl, rr);
    tick_in_t w;
    w.goal_vx  = gx;
    w.goal_vy  = gy;
    w.goal_wz  = gw;
    w.wheel_fr = fr;
    w.wheel_fl = fl;
    w.wheel_rl = rl;
    w.wheel_rr = rr;
    return w;
  endfunction

  // With all gains at zero the commands and the twist are zero, and only the errors remain.
  function automatic tick_out_t known_err(logic signed [15:0] ex, ey, ew);
    tick_out_t r;
    r = '0;
    r.err_vx = ex;
    r.err_vy = ey;
    r.err_wz = ew;
    return r;
  endfunction

  function automatic void add_tick(tick_in_t w);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.word = w;
    plan.push_back(r);
  endfunction

  function automatic void add_known(tick_in_t w, tick_out_t res);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_KNOWN;
    r.word  = w;
    r.known = res;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (!idle_on) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] pick_speed(bit allow_zero);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (allow_zero && sel < 10) return 16'sd0;
    if (sel < 18) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    if (sel < 40) return 16'(int'($urandom_range(0, 4095)) - 2048);
    return 16'($urandom);
  endfunction

  // Gains: extremes, zero, values near unity so the outputs stay off the rails, or anything.
  function automatic logic [DataW-1:0] pick_gain();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 16'h7fff;
    if (sel < 20) return 16'h8000;
    if (sel < 28) return 16'h0000;
    if (sel < 70) return 16'(int'($urandom_range(0, 1023)) - 512);
    return 16'($urandom);
  endfunction

  // In windup phases the forward setpoint sits just below full scale and is never zero.
  function automatic tick_in_t random_tick(bit windup);
    tick_in_t w;
    if (windup) begin
      w.goal_vx = 16'(32767 - int'($urandom_range(0, 15)));
    end else begin
      w.goal_vx = pick_speed(1'b1);
    end
    w.goal_vy  = pick_speed(1'b1);
    w.goal_wz  = pick_speed(1'b1);
    w.wheel_fr = pick_speed(1'b1);
    w.wheel_fl = pick_speed(1'b1);
    w.wheel_rl = pick_speed(1'b1);
    w.wheel_rr = pick_speed(1'b1);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge only.
  // ---------------------------------------------------------------------------

  // Offer one word, after an optional gap, and return once it has been taken.
  // Valid is left high so back-to-back words keep it high without a glitch.
  task automatic send_word(input tick_in_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.goal_vx           = w.goal_vx;
    in_ch.goal_vy           = w.goal_vy;
    in_ch.goal_wz           = w.goal_wz;
    in_ch.wheel_front_right = w.wheel_fr;
    in_ch.wheel_front_left  = w.wheel_fl;
    in_ch.wheel_rear_left   = w.wheel_rl;
    in_ch.wheel_rear_right  = w.wheel_rr;
    in_ch.valid             = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Send a word and queue its expected result; a typed-in result replaces the prediction,
  // but the predictor still runs so that its state keeps up with the block.
  task automatic issue_tick(input tick_in_t w, input bit use_known, input tick_out_t known);
    tick_out_t want;
    send_word(w);
    want = control_tick(w);
    if (use_known) want = known;
    pending_cmds.push_back(want);
    ticks_sent++;
  endtask

  // Stop offering words and wait until every outstanding result has been collected.
  task automatic finish_burst();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_GAIN_YAW_ERR: k_gain_yaw_err = val;
      CFG_GAIN_YAW_INT: k_gain_yaw_int = val;
      CFG_GAIN_X_ERR:   k_gain_x_err   = val;
      CFG_GAIN_X_INT:   k_gain_x_int   = val;
      CFG_GAIN_Y_ERR:   k_gain_y_err   = val;
      CFG_GAIN_Y_INT:   k_gain_y_int   = val;
      CFG_TICK_PERIOD:  k_tick         = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req   = 1'b0;
      end
      if (stall_left != 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result word is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("result %0d, %s: expected %0d, got %0d", results_seen, name,
                 $signed(want), $signed(got));
      end
    end
  endfunction

  always @(posedge clk_i) begin
    tick_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result %0d arrived with no word outstanding", results_seen);
        end
      end else begin
        want = pending_cmds.pop_front();
        check_field("cmd_wheel_one", want.cmd_one, out_ch.cmd_wheel_one);
        check_field("cmd_wheel_two", want.cmd_two, out_ch.cmd_wheel_two);
        check_field("cmd_wheel_three", want.cmd_three, out_ch.cmd_wheel_three);
        check_field("cmd_wheel_four", want.cmd_four, out_ch.cmd_wheel_four);
        check_field("twist_vx", want.twist_vx, out_ch.twist_vx);
        check_field("twist_vy", want.twist_vy, out_ch.twist_vy);
        check_field("twist_wz", want.twist_wz, out_ch.twist_wz);
        check_field("err_vx", want.err_vx, out_ch.err_vx);
        check_field("err_vy", want.err_vy, out_ch.err_vy);
        check_field("err_wz", want.err_wz, out_ch.err_wz);
      end
      results_seen++;
    end
  end

  // Watchdog: a long run of cycles in which no word and no register write moves means a hang.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
             WatchdogLimit, pending_cmds.size());
    $display("[mecanum_lqi_velocity_control] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    bit windup;
    int unsigned phase_ticks;
    logic [DataW-1:0] gain;

    // Every input of the block is known from time zero.
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = '0;
    cfg_data_i              = '0;
    in_ch.valid             = 1'b0;
    in_ch.goal_vx           = '0;
    in_ch.goal_vy           = '0;
    in_ch.goal_wz           = '0;
    in_ch.wheel_front_right = '0;
    in_ch.wheel_front_left  = '0;
    in_ch.wheel_rear_left   = '0;
    in_ch.wheel_rear_right  = '0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    ticks_sent   = 0;
    reg_writes   = 0;
    results_seen = 0;
    mismatches   = 0;
    clamp_hits   = 0;

    // Reset state of the mirror: gains zero, tick period at about 1/200 s, state cleared.
    k_gain_yaw_err = '0;
    k_gain_yaw_int = '0;
    k_gain_x_err   = '0;
    k_gain_x_int   = '0;
    k_gain_y_err   = '0;
    k_gain_y_int   = '0;
    k_tick         = 16'd328;
    acc_vx  = '0;
    acc_vy  = '0;
    acc_wz  = '0;
    body_vx = '0;
    body_vy = '0;
    body_wz = '0;

    // Straight after reset every gain is zero, so the commands and the twist are zero
    // and the errors equal the setpoints while the estimate is still zero.
    add_known(tk(0, 0, 0, 0, 0, 0, 0), known_err(0, 0, 0));
    add_known(tk(32767, -32768, 1, 0, 0, 0, 0), known_err(32767, -32768, 1));
    add_known(tk(-32768, 32767, -1, 0, 0, 0, 0), known_err(-32768, 32767, -1));
    // Full-scale wheels: no effect on this word, only on the next estimate.
    add_known(tk(0, 0, 0, 32767, 32767, 32767, 32767), known_err(0, 0, 0));
    add_tick(tk(0, 0, 0, -32768, -32768, -32768, -32768));
    add_tick(tk(100, -100, 0, 32767, -32768, 32767, -32768));
    add_tick(tk(-5, 5, 7, 32767, -32768, -32768, 32767));

    // Every register at an extreme, including the longest tick period.
    add_reg(CFG_GAIN_YAW_ERR, 16'h7fff);
    add_reg(CFG_GAIN_YAW_INT, 16'h8000);
    add_reg(CFG_GAIN_X_ERR, 16'h7fff);
    add_reg(CFG_GAIN_X_INT, 16'h7fff);
    add_reg(CFG_GAIN_Y_ERR, 16'h8000);
    add_reg(CFG_GAIN_Y_INT, 16'h8000);
    add_reg(CFG_TICK_PERIOD, 16'hffff);
    add_tick(tk(32767, 32767, 32767, 0, 0, 0, 0));
    add_tick(tk(32767, 32767, 32767, -32768, 0, 32767, 0));
    // A zero setpoint on one axis at a time clears that integrator.
    add_tick(tk(0, 32767, -32768, 0, 0, 0, 0));
    add_tick(tk(-32768, 0, 1, 1, -1, 1, -1));
    add_tick(tk(1, -1, 0, 0, 0, 0, 0));

    // Zero tick period: integrators hold their value.
    add_reg(CFG_GAIN_YAW_ERR, 16'h0100);
    add_reg(CFG_GAIN_X_INT, 16'h0100);
    add_reg(CFG_GAIN_Y_INT, 16'hff00);
    add_reg(CFG_TICK_PERIOD, 16'h0000);
    add_tick(tk(1024, -1024, 512, 0, 0, 0, 0));
    add_tick(tk(2048, -2048, 256, 1000, -1000, 500, -500));
    add_tick(tk(-3000, 3000, -700, 0, 0, 0, 0));

    // A write to the unused index must change nothing; shortest nonzero tick period.
    add_reg(CfgIdxSpare, 16'hffff);
    add_reg(CFG_TICK_PERIOD, 16'h0001);
    add_tick(tk(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555));
    add_tick(tk(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa));
    add_tick(tk(333, 444, -555, 12, -34, 56, -78));

    // Small negative gains keep the outputs off the rails so rounding shows.
    add_reg(CFG_GAIN_YAW_ERR, 16'hfe00);
    add_reg(CFG_GAIN_YAW_INT, 16'hff80);
    add_reg(CFG_GAIN_X_ERR, 16'hff00);
    add_reg(CFG_GAIN_X_INT, 16'hffc0);
    add_reg(CFG_GAIN_Y_ERR, 16'hfd80);
    add_reg(CFG_GAIN_Y_INT, 16'hff40);
    add_reg(CFG_TICK_PERIOD, 16'd328);
    add_tick(tk(511, -513, 3, 7, -9, 11, -13));
    add_tick(tk(1, 1, 1, -1, -1, -1, -1));
    add_tick(tk(-1, -1, -1, 1, 1, 1, 1));
    add_tick(tk(20000, -20000, 10000, 4000, -4000, 2000, -2000));

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed plan. Register rows first let the block run dry.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        finish_burst();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        issue_tick(plan[i].word, plan[i].kind == ROW_KNOWN, plan[i].known);
      end
    end

    // Random phases. The first ones wind the forward integrator up to its clamp with the
    // longest tick period; gains change between them, the integrator carries over.
    for (int ph = 0; ph < NumPhases; ph++) begin
      windup = (ph < WindupPhases);
      phase_ticks = windup ? WindupTicks : MixedTicks;
      finish_burst();
      idle_on = (ph % 2 == 0);
      for (int r = 0; r < 6; r++) begin
        if (ph == 1) begin
          gain = 16'h7fff;
        end else if (ph == 2) begin
          gain = 16'h8000;
        end else begin
          gain = pick_gain();
        end
        write_reg(CfgIdxW'(r), gain);
      end
      if (windup) begin
        write_reg(CFG_TICK_PERIOD, 16'hffff);
      end else if (ph == NumPhases - 1) begin
        write_reg(CFG_TICK_PERIOD, 16'h0001);
      end else begin
        write_reg(CFG_TICK_PERIOD, 16'($urandom));
      end
      write_reg(CfgIdxSpare, 16'($urandom));
      for (int n = 0; n < phase_ticks; n++) begin
        // The result side holds off for a long stretch while words keep coming,
        // so the block fills and has to stall its input.
        if (ph == 1 && n == 40) hold_req = 1'b1;
        // Once, the sender pauses mid-phase until every result is back.
        if (ph == 2 && n == 100) finish_burst();
        issue_tick(random_tick(windup), 1'b0, '0);
      end
    end

    finish_burst();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_cmds.size() != 0) begin
      $display("%0d results never arrived", pending_cmds.size());
      mismatches += pending_cmds.size();
    end

    $display("Sent %0d control ticks across %0d register writes; %0d results checked.",
             ticks_sent, reg_writes, results_seen);
    $display("Integrator clamp reached on %0d axis updates; %0d mismatching fields.",
             clamp_hits, mismatches);
    if (mismatches == 0) begin
      $display("[mecanum_lqi_velocity_control] OK");
    end else begin
      $display("[mecanum_lqi_velocity_control] ERROR");
    end
    $finish;
  end

endmodule

// ----- mecanum_lqi_velocity_control.f -----
rtl/mlvc_pkg.sv
rtl/mlvc_if.sv
rtl/mlvc_axis_lane.sv
rtl/mlvc_estimator.sv
rtl/mlvc_merge.sv
rtl/mecanum_lqi_velocity_control.sv
bench/mecanum_lqi_velocity_control_tb.sv
